FILE: rtl/core/id3fs_pkg.sv
// ----------------------------------------------------------------------------
// id3fs_pkg
// shared types and constants of the id3v2.4 tag frame splitter
// ----------------------------------------------------------------------------
package id3fs_pkg;

  // parser phase
  typedef enum logic [2:0] {
    PH_TAG      = 3'd0,
    PH_FHDR     = 3'd1,
    PH_PAY      = 3'd2,
    PH_DONE     = 3'd3,
    PH_BADMAGIC = 3'd4,
    PH_BADVER   = 3'd5
  } phase_e;

  // classification of each result byte
  typedef enum logic [2:0] {
    KIND_TAG_HDR   = 3'd0,
    KIND_FRAME_HDR = 3'd1,
    KIND_PAYLOAD   = 3'd2,
    KIND_AFTER_END = 3'd3,
    KIND_REJECTED  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_PARSING     = 2'd0,
    ST_BAD_MAGIC   = 2'd1,
    ST_BAD_VERSION = 2'd2,
    ST_COMPLETE    = 2'd3
  } status_e;

  localparam logic [7:0] MAGIC_0 = 8'h49;  // 'I'
  localparam logic [7:0] MAGIC_1 = 8'h44;  // 'D'
  localparam logic [7:0] MAGIC_2 = 8'h33;  // '3'

  localparam logic [7:0] RESET_VERSION = 8'd4;

  // byte positions inside a 10-byte header
  localparam logic [3:0] MAGIC_BYTES   = 4'd3;
  localparam logic [3:0] VERSION_POS   = 4'd3;
  localparam logic [3:0] TAG_SIZE_POS  = 4'd6;
  localparam logic [3:0] ID_END_POS    = 4'd4;
  localparam logic [3:0] SIZE_END_POS  = 4'd8;
  localparam logic [3:0] HDR_LAST_POS  = 4'd9;

  localparam logic [30:0] FRAME_HDR_BYTES = 31'd10;

  // classified byte as it travels through the queue
  typedef struct packed {
    logic [7:0] data;
    logic       file_start;
    logic [2:0] magic_hit;
    logic       version_ok;
  } entry_t;

endpackage

FILE: rtl/core/id3fs_front.sv
// ----------------------------------------------------------------------------
// id3fs_front
// input side: accepts bytes and tags them with magic and version matches
// ----------------------------------------------------------------------------
module id3fs_front (
  input  logic              in_valid_i,
  input  logic [7:0]        data_byte_i,
  input  logic              file_start_i,
  input  logic [7:0]        accepted_version_i,
  input  logic              queue_full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output id3fs_pkg::entry_t entry_o
);

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i & ~queue_full_i;

  always_comb begin
    entry_o.data         = data_byte_i;
    entry_o.file_start   = file_start_i;
    entry_o.magic_hit[0] = (data_byte_i == id3fs_pkg::MAGIC_0);
    entry_o.magic_hit[1] = (data_byte_i == id3fs_pkg::MAGIC_1);
    entry_o.magic_hit[2] = (data_byte_i == id3fs_pkg::MAGIC_2);
    entry_o.version_ok   = (data_byte_i == accepted_version_i);
  end

endmodule

FILE: rtl/core/id3fs_queue.sv
// ----------------------------------------------------------------------------
// id3fs_queue
// short queue of classified bytes between front and back
// ----------------------------------------------------------------------------
module id3fs_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  id3fs_pkg::entry_t entry_i,
  input  logic              pop_i,
  output logic              valid_o,
  output logic              full_o,
  output id3fs_pkg::entry_t entry_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  id3fs_pkg::entry_t mem_q [DEPTH];

  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: rtl/core/id3fs_back.sv
// ----------------------------------------------------------------------------
// id3fs_back
// parser state machine and result register
// ----------------------------------------------------------------------------
module id3fs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              entry_valid_i,
  input  id3fs_pkg::entry_t entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        byte_kind_o,
  output logic [7:0]        payload_byte_o,
  output logic              frame_header_done_o,
  output logic [31:0]       frame_id_o,
  output logic [27:0]       frame_length_o,
  output logic              payload_last_o,
  output logic [1:0]        parse_status_o
);

  id3fs_pkg::phase_e phase_q, phase_d, phase_cur;
  logic [3:0]  hc_q, hc_d, hc_cur;
  logic [27:0] tag_q, tag_d, tag_cur;
  logic [29:0] cons_q, cons_d, cons_cur;
  logic [31:0] id_q, id_d, id_cur;
  logic [27:0] size_q, size_d, size_cur;
  logic [27:0] left_q, left_d, left_cur;

  logic [7:0]  b;
  logic        fs;
  logic [27:0] tag_shifted;
  logic [27:0] size_shifted;
  logic [31:0] id_shifted;
  logic [30:0] sum;
  logic [29:0] cons_sat;
  logic        more_after_hdr;
  logic        more_after_pay;
  logic [27:0] left_dec;
  logic        bad_magic;
  logic        bad_ver;

  // result register
  logic        out_valid_q;
  id3fs_pkg::kind_e   kind_d, kind_q;
  id3fs_pkg::status_e status_d, status_q;
  logic [7:0]  pbyte_d, pbyte_q;
  logic        hdone_d, hdone_q;
  logic [31:0] fid_d, fid_q;
  logic [27:0] flen_d, flen_q;
  logic        plast_d, plast_q;

  assign pop_o = entry_valid_i & (~out_valid_q | ~out_stall_i);

  assign b  = entry_i.data;
  assign fs = entry_i.file_start;

  // a file start clears the parse state before this byte
  assign phase_cur = fs ? id3fs_pkg::PH_TAG : phase_q;
  assign hc_cur    = fs ? 4'd0  : hc_q;
  assign tag_cur   = fs ? '0    : tag_q;
  assign cons_cur  = fs ? '0    : cons_q;
  assign id_cur    = fs ? '0    : id_q;
  assign size_cur  = fs ? '0    : size_q;
  assign left_cur  = fs ? '0    : left_q;

  assign tag_shifted  = {tag_cur[20:0], b[6:0]};
  assign size_shifted = {size_cur[20:0], b[6:0]};
  assign id_shifted   = {id_cur[23:0], b};

  // consumed count after this frame header, saturating at 30 bits
  assign sum      = {1'b0, cons_cur} + id3fs_pkg::FRAME_HDR_BYTES + {3'b000, size_cur};
  assign cons_sat = sum[30] ? '1 : sum[29:0];

  assign more_after_hdr = (cons_sat < {2'b00, tag_cur});
  assign more_after_pay = (cons_cur < {2'b00, tag_cur});
  assign left_dec       = left_cur - {27'd0, (left_cur != '0)};

  assign bad_magic = (phase_cur == id3fs_pkg::PH_TAG) && (hc_cur < id3fs_pkg::MAGIC_BYTES)
                     && !entry_i.magic_hit[hc_cur[1:0]];
  assign bad_ver   = (phase_cur == id3fs_pkg::PH_TAG) && (hc_cur == id3fs_pkg::VERSION_POS)
                     && !entry_i.version_ok;

  // next state
  always_comb begin
    phase_d = phase_cur;
    hc_d    = hc_cur;
    tag_d   = tag_cur;
    cons_d  = cons_cur;
    id_d    = id_cur;
    size_d  = size_cur;
    left_d  = left_cur;
    case (phase_cur)
      id3fs_pkg::PH_TAG: begin
        if (bad_magic) begin
          phase_d = id3fs_pkg::PH_BADMAGIC;
        end else if (bad_ver) begin
          phase_d = id3fs_pkg::PH_BADVER;
        end else begin
          if (hc_cur >= id3fs_pkg::TAG_SIZE_POS) begin
            tag_d = tag_shifted;
          end
          if (hc_cur >= id3fs_pkg::HDR_LAST_POS) begin
            cons_d  = '0;
            hc_d    = 4'd0;
            phase_d = (tag_shifted != '0) ? id3fs_pkg::PH_FHDR : id3fs_pkg::PH_DONE;
          end else begin
            hc_d = hc_cur + 4'd1;
          end
        end
      end
      id3fs_pkg::PH_FHDR: begin
        if (hc_cur < id3fs_pkg::ID_END_POS) begin
          id_d = id_shifted;
        end else if (hc_cur < id3fs_pkg::SIZE_END_POS) begin
          size_d = size_shifted;
        end
        if (hc_cur >= id3fs_pkg::HDR_LAST_POS) begin
          cons_d = cons_sat;
          hc_d   = 4'd0;
          if (size_cur == '0) begin
            phase_d = more_after_hdr ? id3fs_pkg::PH_FHDR : id3fs_pkg::PH_DONE;
          end else begin
            left_d  = size_cur;
            phase_d = id3fs_pkg::PH_PAY;
          end
        end else begin
          hc_d = hc_cur + 4'd1;
        end
      end
      id3fs_pkg::PH_PAY: begin
        left_d = left_dec;
        if (left_dec == '0) begin
          hc_d    = 4'd0;
          phase_d = more_after_pay ? id3fs_pkg::PH_FHDR : id3fs_pkg::PH_DONE;
        end
      end
      default: begin
        phase_d = phase_cur;
      end
    endcase
  end

  // result fields
  always_comb begin
    kind_d   = id3fs_pkg::KIND_TAG_HDR;
    status_d = id3fs_pkg::ST_PARSING;
    pbyte_d  = 8'd0;
    hdone_d  = 1'b0;
    fid_d    = '0;
    flen_d   = '0;
    plast_d  = 1'b0;
    case (phase_cur)
      id3fs_pkg::PH_TAG: begin
        if (bad_magic) begin
          kind_d   = id3fs_pkg::KIND_REJECTED;
          status_d = id3fs_pkg::ST_BAD_MAGIC;
        end else if (bad_ver) begin
          kind_d   = id3fs_pkg::KIND_REJECTED;
          status_d = id3fs_pkg::ST_BAD_VERSION;
        end else if ((hc_cur >= id3fs_pkg::HDR_LAST_POS) && (tag_shifted == '0)) begin
          status_d = id3fs_pkg::ST_COMPLETE;
        end
      end
      id3fs_pkg::PH_FHDR: begin
        kind_d = id3fs_pkg::KIND_FRAME_HDR;
        if (hc_cur >= id3fs_pkg::HDR_LAST_POS) begin
          hdone_d = 1'b1;
          fid_d   = id_cur;
          flen_d  = size_cur;
          if (size_cur == '0) begin
            plast_d = 1'b1;
            if (!more_after_hdr) begin
              status_d = id3fs_pkg::ST_COMPLETE;
            end
          end
        end
      end
      id3fs_pkg::PH_PAY: begin
        kind_d  = id3fs_pkg::KIND_PAYLOAD;
        pbyte_d = b;
        if (left_dec == '0) begin
          plast_d = 1'b1;
          if (!more_after_pay) begin
            status_d = id3fs_pkg::ST_COMPLETE;
          end
        end
      end
      id3fs_pkg::PH_DONE: begin
        kind_d   = id3fs_pkg::KIND_AFTER_END;
        status_d = id3fs_pkg::ST_COMPLETE;
      end
      id3fs_pkg::PH_BADMAGIC: begin
        kind_d   = id3fs_pkg::KIND_REJECTED;
        status_d = id3fs_pkg::ST_BAD_MAGIC;
      end
      default: begin
        kind_d   = id3fs_pkg::KIND_REJECTED;
        status_d = id3fs_pkg::ST_BAD_VERSION;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= id3fs_pkg::PH_TAG;
      hc_q        <= 4'd0;
      tag_q       <= '0;
      cons_q      <= '0;
      id_q        <= '0;
      size_q      <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d;
        hc_q    <= hc_d;
        tag_q   <= tag_d;
        cons_q  <= cons_d;
        id_q    <= id_d;
        size_q  <= size_d;
        left_q  <= left_d;
      end
      out_valid_q <= pop_o | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q   <= kind_d;
      status_q <= status_d;
      pbyte_q  <= pbyte_d;
      hdone_q  <= hdone_d;
      fid_q    <= fid_d;
      flen_q   <= flen_d;
      plast_q  <= plast_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign byte_kind_o         = kind_q;
  assign payload_byte_o      = pbyte_q;
  assign frame_header_done_o = hdone_q;
  assign frame_id_o          = fid_q;
  assign frame_length_o      = flen_q;
  assign payload_last_o      = plast_q;
  assign parse_status_o      = status_q;

  // header byte index never runs past the last header byte
  a_hc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hc_q <= id3fs_pkg::HDR_LAST_POS)
    else $error("header byte index out of range");

  // payload phase always has bytes left to pass
  a_pay_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == id3fs_pkg::PH_PAY) |-> (left_q != '0))
    else $error("payload phase with nothing left");

  // tag end is sticky until a file start comes through
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == id3fs_pkg::PH_DONE) && !(pop_o && fs)) |=> (phase_q == id3fs_pkg::PH_DONE))
    else $error("left tag end without file start");

  // a new result only appears after a byte was taken from the queue
  a_out_from_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pop_o))
    else $error("result without queue pop");

endmodule

FILE: rtl/core/id3v24_tag_frame_splitter.sv
// ----------------------------------------------------------------------------
// id3v24_tag_frame_splitter
// byte-serial splitter of an id3v2 tag into frames
// ----------------------------------------------------------------------------
// takes a file one byte per transaction and returns one result transaction for
// every byte: the byte's kind (tag header, frame header, payload, after tag end,
// rejected), the payload byte itself, a header-done flag carrying the frame id
// and its decoded syncsafe length, a last-payload flag and the parse status.
// the tag must start with "ID3" and carry the major version held in the one
// configuration register (reset value 4); a mismatch rejects the rest of the
// file until a byte arrives with file_start_i high. while the output is not
// stalled the block sustains one byte per clock cycle with back-to-back
// transactions on both channels. the result of a byte passes through the
// queue and then the result register before it reaches the output. the one
// byte per cycle is held by the parser loop in the back end, which per byte
// advances the header counters and does one 30-bit add and compare of the
// consumed count against the tag size. a short queue separates the input
// classifier from the parser, so the input keeps flowing for up to
// QUEUE_DEPTH bytes while a finished result waits in the output register; a
// full queue takes no byte in the cycle it drains, so the input is still
// stalled while the first byte drains after an output stall ends.
// ----------------------------------------------------------------------------
module id3v24_tag_frame_splitter #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // input byte channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        file_start_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  byte_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        frame_header_done_o,
  output logic [31:0] frame_id_o,
  output logic [27:0] frame_length_o,
  output logic        payload_last_o,
  output logic [1:0]  parse_status_o
);

  // accepted major version; the user must write it only while the block is idle, the block does not enforce this
  logic [7:0] accepted_version_q;

  // front to queue
  logic              push;
  id3fs_pkg::entry_t front_entry;
  logic              queue_full;

  // queue to back
  logic              queue_valid;
  id3fs_pkg::entry_t queue_entry;
  logic              pop;

  // the register is always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accepted_version_q <= id3fs_pkg::RESET_VERSION;
    end else if (cfg_valid_i && cfg_ready_o) begin
      accepted_version_q <= cfg_data_i;
    end
  end

  // front: accept and classify each byte
  id3fs_front u_front (
    .in_valid_i         (in_valid_i),
    .data_byte_i        (data_byte_i),
    .file_start_i       (file_start_i),
    .accepted_version_i (accepted_version_q),
    .queue_full_i       (queue_full),
    .in_stall_o         (in_stall_o),
    .push_o             (push),
    .entry_o            (front_entry)
  );

  // decoupling queue
  id3fs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .full_o  (queue_full),
    .entry_o (queue_entry)
  );

  // back: parser and result register
  id3fs_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .entry_valid_i       (queue_valid),
    .entry_i             (queue_entry),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .byte_kind_o         (byte_kind_o),
    .payload_byte_o      (payload_byte_o),
    .frame_header_done_o (frame_header_done_o),
    .frame_id_o          (frame_id_o),
    .frame_length_o      (frame_length_o),
    .payload_last_o      (payload_last_o),
    .parse_status_o      (parse_status_o)
  );

endmodule
